// ===== rtl/irpwfs_pkg.sv =====
// Shared types and constants for the infrared pulse width frame sender.
// Beat payload structs, configuration register map and reset values.
// No dependencies.
package irpwfs_pkg;

    localparam int FRAME_BITS     = 16;
    localparam int BIT_IDX_W      = 5;
    localparam int TICK_W         = 16;
    localparam int CFG_IDX_W      = 4;
    localparam int FIELD_MAX      = 31;
    localparam int COPIES_DEFAULT = 2;

    localparam logic [TICK_W-1:0] LONG_RESET  = 16'd1600;
    localparam logic [TICK_W-1:0] SHORT_RESET = 16'd800;
    localparam logic [TICK_W-1:0] GAP_RESET   = 16'd3000;
    localparam logic [TICK_W-1:0] LEAD_RESET  = 16'd100;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SEND   = 2'd1,
        OP_REPEAT = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG  = 4'd0,
        REG_SHORT = 4'd1,
        REG_GAP   = 4'd2,
        REG_LEAD  = 4'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] player;
        logic [7:0] payload;
    } in_item_t;

    typedef struct packed {
        logic led;
        logic busy_res;
        logic rejected;
    } out_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [TICK_W-1:0] lead_ticks;
        logic              long_nz;
        logic              short_nz;
        logic              gap_nz;
    } cfg_t;

endpackage

// ===== rtl/irpwfs_cfg.sv =====
// Timing register file for the infrared frame sender.
// Write-only registers plus non-zero flags; depends on irpwfs_pkg.
module irpwfs_cfg import irpwfs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_wdata,
    output cfg_t                 cfg
);

    logic [TICK_W-1:0] long_reg;
    logic [TICK_W-1:0] short_reg;
    logic [TICK_W-1:0] gap_reg;
    logic [TICK_W-1:0] lead_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_reg  <= LONG_RESET;
            short_reg <= SHORT_RESET;
            gap_reg   <= GAP_RESET;
            lead_reg  <= LEAD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LONG:  long_reg  <= cfg_wdata;
                REG_SHORT: short_reg <= cfg_wdata;
                REG_GAP:   gap_reg   <= cfg_wdata;
                REG_LEAD:  lead_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.long_ticks  = long_reg;
        cfg.short_ticks = short_reg;
        cfg.gap_ticks   = gap_reg;
        cfg.lead_ticks  = lead_reg;
        cfg.long_nz     = |long_reg;
        cfg.short_nz    = |short_reg;
        cfg.gap_nz      = |gap_reg;
    end

endmodule

// ===== rtl/irpwfs_core.sv =====
// Frame sequencer: command latching, frame build and pulse interval state.
// Resolves all zero-length intervals of one beat in a single pass.
// Depends on irpwfs_pkg.
module irpwfs_core import irpwfs_pkg::*; #(
    parameter int COPIES = COPIES_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      item_go,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    localparam logic [2:0]           COPIES_W = 3'(COPIES);
    localparam logic [BIT_IDX_W-1:0] LEAD_IDX = BIT_IDX_W'(FRAME_BITS);
    localparam logic [3:0]           TOP_BIT  = 4'(FRAME_BITS - 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [BIT_IDX_W-1:0]  bit_idx;
        logic [1:0]            copy;
        logic [TICK_W-1:0]     ticks;
    } seq_t;

    function automatic seq_t enter_bit(input logic [15:0] fr, input logic [3:0] j,
                                       input logic [1:0] cp, input cfg_t c);
        seq_t r;
        logic b;
        b         = fr[j];
        r.bit_idx = {1'b0, j};
        r.copy    = cp;
        if (b ? c.long_nz : c.short_nz) begin
            r.phase = PH_HIGH;
            r.ticks = b ? c.long_ticks : c.short_ticks;
        end else begin
            r.phase = PH_LOW;
            r.ticks = b ? c.short_ticks : c.long_ticks;
        end
        return r;
    endfunction

    // End of one copy; with zero bit widths and no gap the rest go at once.
    function automatic seq_t copy_end(input logic [15:0] fr, input logic [1:0] cp,
                                      input cfg_t c);
        seq_t r;
        logic [1:0] cn;
        logic done;
        cn   = cp + 2'd1;
        done = (cn == 2'd0) || ({1'b0, cn} >= COPIES_W);
        r    = '{phase: PH_IDLE, bit_idx: '0, copy: cn, ticks: '0};
        if (!done) begin
            if (c.gap_nz) begin
                r = '{phase: PH_GAP, bit_idx: LEAD_IDX, copy: cn, ticks: c.gap_ticks};
            end else if (c.long_nz || c.short_nz) begin
                r = enter_bit(fr, TOP_BIT, cn, c);
            end
        end
        return r;
    endfunction

    function automatic seq_t next_bit(input logic [15:0] fr, input seq_t s, input cfg_t c);
        logic [BIT_IDX_W-1:0] dec;
        dec = s.bit_idx - 1'b1;
        if (s.bit_idx == '0 || !(c.long_nz || c.short_nz)) begin
            return copy_end(fr, s.copy, c);
        end
        return enter_bit(fr, dec[3:0], s.copy, c);
    endfunction

    function automatic seq_t resolve(input logic [15:0] fr, input seq_t s, input cfg_t c);
        seq_t r;
        logic b;
        r = s;
        b = fr[s.bit_idx[3:0]];
        if (s.phase != PH_IDLE && s.ticks == '0) begin
            if (s.phase == PH_HIGH && (b ? c.short_nz : c.long_nz)) begin
                r.phase = PH_LOW;
                r.ticks = b ? c.short_ticks : c.long_ticks;
            end else begin
                r = next_bit(fr, s, c);
            end
        end
        return r;
    endfunction

    logic [15:0] frame_reg,       frame_next;
    seq_t        seq_reg,         seq_next;
    logic        pend_send_reg,   pend_send_next;
    logic        pend_repeat_reg, pend_repeat_next;
    logic [7:0]  pend_player_reg, pend_player_next;
    logic [7:0]  pend_data_reg,   pend_data_next;

    logic rej;
    logic settle;
    seq_t s;

    always_comb begin
        frame_next       = frame_reg;
        s                = seq_reg;
        pend_send_next   = pend_send_reg;
        pend_repeat_next = pend_repeat_reg;
        pend_player_next = pend_player_reg;
        pend_data_next   = pend_data_reg;
        rej              = 1'b0;
        settle           = 1'b1;

        case (item.operation)
            OP_TICK: begin
                if (s.phase != PH_IDLE && s.ticks != '0) begin
                    s.ticks = s.ticks - 1'b1;
                end
            end
            OP_SEND: begin
                pend_player_next = item.player;
                pend_data_next   = item.payload;
                pend_send_next   = 1'b1;
                rej = (item.player > 8'(FIELD_MAX)) || (item.payload > 8'(FIELD_MAX));
            end
            OP_REPEAT: pend_repeat_next = 1'b1;
            default:   settle = 1'b0;
        endcase

        if (settle) begin
            s = resolve(frame_next, s, cfg);
            // At most two pickups per beat: one per pending flag.
            for (int k = 0; k < 2; k++) begin
                if (s.phase == PH_IDLE && (pend_send_next || pend_repeat_next)) begin
                    if (pend_send_next) begin
                        pend_send_next = 1'b0;
                        if (pend_player_next <= 8'(FIELD_MAX) &&
                            pend_data_next <= 8'(FIELD_MAX)) begin
                            frame_next = {1'b1, pend_player_next[4:0], pend_data_next[4:0],
                                          pend_player_next[4:0] ^ pend_data_next[4:0]};
                        end
                    end else begin
                        pend_repeat_next = 1'b0;
                    end
                    s = '{phase: PH_LEAD, bit_idx: LEAD_IDX, copy: 2'd0,
                          ticks: cfg.lead_ticks};
                    s = resolve(frame_next, s, cfg);
                end
            end
        end

        seq_next = s;
        result.led      = (s.phase == PH_HIGH);
        result.busy_res = (s.phase != PH_IDLE);
        result.rejected = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg       <= '0;
            seq_reg         <= '{phase: PH_IDLE, bit_idx: '0, copy: '0, ticks: '0};
            pend_send_reg   <= 1'b0;
            pend_repeat_reg <= 1'b0;
            pend_player_reg <= '0;
            pend_data_reg   <= '0;
        end else if (item_go) begin
            frame_reg       <= frame_next;
            seq_reg         <= seq_next;
            pend_send_reg   <= pend_send_next;
            pend_repeat_reg <= pend_repeat_next;
            pend_player_reg <= pend_player_next;
            pend_data_reg   <= pend_data_next;
        end
    end

endmodule

// ===== rtl/ir_pulse_width_frame_sender.sv =====
// Top level of the infrared pulse width frame sender.
// Input register, sequencer core, result register; depends on irpwfs_pkg,
// irpwfs_cfg and irpwfs_core.
//
//   port group   dir  handshake          payload
//   s_*          in   s_valid / s_ready  in_item_t  (operation, player, payload)
//   m_*          out  m_valid / m_ready  out_item_t (led, busy_res, rejected)
//   cfg_*        in   cfg_we             cfg_index, cfg_wdata
//
// One beat per clock sustained while m_ready stays high.
// Latency is set by the input register and the result register; the whole
// interval and pickup update of a beat sits between them.
// Synchronous active-low reset; timing registers return to their defaults.
// A stalled result holds the pipe; an empty input register takes one more
// beat, then s_ready drops until the result is taken.
module ir_pulse_width_frame_sender import irpwfs_pkg::*; #(
    parameter int COPIES = COPIES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_wdata
);

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      m_valid_reg;
    out_item_t m_data_reg;
    out_item_t core_result;
    cfg_t      cfg;
    logic      advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    irpwfs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    irpwfs_core #(
        .COPIES (COPIES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_go (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= core_result;
        end
    end

endmodule
